// ----- rtl/dq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg: shared types and codes of the double-ended queue
// Item layouts for both channels, command and status codes, and the control
// group that the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package dq_pkg;

    // Command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_BACK   = 3'd3;
    localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
    localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Input item
    typedef struct packed {
        logic        [2:0]  command;
        logic signed [31:0] value_in;
    } dq_in_t;

    // Result item
    typedef struct packed {
        logic signed [31:0] value_out;
        logic        [6:0]  occupancy;
        logic        [1:0]  status;
    } dq_out_t;

    // Per-cycle shift control seen by every cell
    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
    } dq_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/dq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dq_cell: one storage slot of the queue chain
// Holds one word. Shifts toward the back on a front push, toward the front on
// a front pop, and loads the pushed word when it is the first free slot on a
// back push. Flags its word when it holds the back entry.
// ----------------------------------------------------------------------------
module dq_cell
    import dq_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
) (
    input  wire logic                  aclk,
    input  wire dq_ctrl_t              ctrl,
    input  wire logic [CNT_W-1:0]      count,
    input  wire logic [DATA_WIDTH-1:0] push_word,
    input  wire logic [DATA_WIDTH-1:0] left_word,
    input  wire logic [DATA_WIDTH-1:0] right_word,
    output logic      [DATA_WIDTH-1:0] cell_word,
    output logic      [DATA_WIDTH-1:0] back_word
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  is_free_head;
    logic                  is_back;

    assign is_free_head = (count == CNT_W'(INDEX));
    assign is_back      = (count == CNT_W'(INDEX + 1));

    // Pick the next word: shift in from a neighbor or load the pushed item
    always_comb begin
        data_next = data_reg;
        priority if (ctrl.push_front) begin
            data_next = left_word;
        end else if (ctrl.push_back && is_free_head) begin
            data_next = push_word;
        end else if (ctrl.pop_front) begin
            data_next = right_word;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign cell_word = data_reg;
    assign back_word = data_reg & {DATA_WIDTH{is_back}};

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque built as a chain of shifting cells
// The front entry always sits in cell 0 and the entries stay packed toward it;
// a front push shifts the chain back by one, a front pop shifts it forward.
// ----------------------------------------------------------------------------
//  channel | ports                      | carries
//  --------+----------------------------+------------------------------------
//  input   | s_valid, s_ready, s_item   | command, value_in
//  result  | m_valid, m_ready, m_item   | value_out, occupancy, status
//
//  The command is decoded and the chain updated in the cycle the item is
//  accepted; the result appears in the output register.
//  The back word is collected by an AND-OR over all cells in that cycle.
//  s_ready is high while the output register is empty or being drained.
//  Reset clears the count and the output valid; cell contents stay as is.
// ----------------------------------------------------------------------------
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire dq_in_t  s_item,
    output logic         m_valid,
    input  wire logic    m_ready,
    output dq_out_t      m_item
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_valid_reg;
    dq_out_t               m_item_reg;
    dq_out_t               m_item_next;
    logic                  s_fire;
    logic                  q_empty;
    logic                  q_full;
    dq_ctrl_t              ctrl;
    logic [DATA_WIDTH-1:0] push_word;
    logic [DATA_WIDTH-1:0] front_word;
    logic [DATA_WIDTH-1:0] back_word;
    logic [DATA_WIDTH-1:0] read_word;
    logic [DATA_WIDTH-1:0] cell_words [DEPTH];
    logic [DATA_WIDTH-1:0] back_words [DEPTH];
    logic [1:0]            status_next;
    logic                  read_valid;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign q_empty = (count_reg == '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));

    assign push_word = DATA_WIDTH'($unsigned(s_item.value_in));

    // Decode the command into chain control, status and new count
    always_comb begin
        ctrl        = '0;
        status_next = ST_OK;
        count_next  = count_reg;
        read_valid  = 1'b0;
        read_word   = front_word;
        unique case (s_item.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (q_full) begin
                    status_next = ST_FULL;
                end else begin
                    ctrl.push_front = (s_item.command == CMD_PUSH_FRONT);
                    ctrl.push_back  = (s_item.command == CMD_PUSH_BACK);
                    count_next      = count_reg + 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
                if (q_empty) begin
                    status_next = ST_EMPTY;
                end else begin
                    read_valid = 1'b1;
                    if (s_item.command == CMD_POP_BACK ||
                        s_item.command == CMD_PEEK_BACK) begin
                        read_word = back_word;
                    end
                    ctrl.pop_front = (s_item.command == CMD_POP_FRONT);
                    if (s_item.command == CMD_POP_FRONT ||
                        s_item.command == CMD_POP_BACK) begin
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (!s_fire) begin
            ctrl       = '0;
            count_next = count_reg;
        end
    end

    // Chain of storage cells; cell 0 takes the pushed word on a front push
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = push_word;
        end else begin : g_mid_l
            assign left_w = cell_words[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_words[i+1];
        end
        dq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .count      (count_reg),
            .push_word  (push_word),
            .left_word  (left_w),
            .right_word (right_w),
            .cell_word  (cell_words[i]),
            .back_word  (back_words[i])
        );
    end

    assign front_word = cell_words[0];

    // Collect the back word: exactly one cell flags itself when not empty
    always_comb begin
        back_word = '0;
        for (int k = 0; k < DEPTH; k++) begin
            back_word = back_word | back_words[k];
        end
    end

    // Build the result item
    always_comb begin
        m_item_next.value_out = read_valid ? 32'(read_word) : '0;
        m_item_next.occupancy = 7'(count_next);
        m_item_next.status    = status_next;
    end

    // Count and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload, loaded on accept
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && q_full && (s_item.command == CMD_PUSH_FRONT ||
                              s_item.command == CMD_PUSH_BACK))
        |=> (m_item_reg.status == ST_FULL) && $stable(count_reg))
        else $error("push on full queue not rejected");

    a_empty_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && q_empty && (s_item.command == CMD_POP_FRONT ||
                               s_item.command == CMD_POP_BACK))
        |=> (m_item_reg.status == ST_EMPTY) && $stable(count_reg))
        else $error("pop on empty queue not rejected");

    a_occ_match: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid_reg && (m_item_reg.occupancy == 7'(count_reg)))
        else $error("reported occupancy differs from count");

    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(count_reg))
        else $error("count changed without an accepted item");

endmodule

`default_nettype wire
